/* src/scli_pkg.sv */
// ----------------------------------------------------------------------------
// scli_pkg
// Shared types of the sine/cosine table interpolator: the input and result
// words and the stage load enables that the top level hands to the datapath.
// ----------------------------------------------------------------------------
package scli_pkg;

  // Input word: angle as an unsigned fraction of one turn, plus a flag that
  // marks a non-finite angle.
  typedef struct packed {
    logic [23:0] phase;
    logic        angle_invalid;
  } scli_in_t;

  // Result word: signed Q2.14 cosine and sine.
  typedef struct packed {
    logic signed [15:0] cosine;
    logic signed [15:0] sine;
  } scli_out_t;

  // Load enables of the stages behind the index stage.
  typedef struct packed {
    logic rom;   // table read registers
    logic diff;  // endpoint and difference registers
    logic mult;  // product registers
    logic res;   // result registers
  } scli_en_t;

endpackage

/* src/scli_rom.sv */
// ----------------------------------------------------------------------------
// scli_rom
// Constant sine table, split into an even bank and an odd bank so that the
// two neighboring entries of any index come out of one read per bank.
// ----------------------------------------------------------------------------
module scli_rom #(
  parameter int LUT_SIZE      = 1024,
  parameter int AMP_FRAC_BITS = 14,
  localparam int IdxW         = $clog2(LUT_SIZE),
  localparam int AmpW         = AMP_FRAC_BITS + 2
) (
  input  logic                   clk_i,
  input  logic                   ld_i,
  input  logic [IdxW-1:0]        idx_i,
  output logic signed [AmpW-1:0] a_o,
  output logic signed [AmpW-1:0] b_o
);

  localparam int EvenDepth = LUT_SIZE / 2 + 1;
  localparam int OddDepth  = (LUT_SIZE + 1) / 2;
  localparam int EaddrW    = $clog2(EvenDepth);
  localparam int OaddrW    = $clog2(OddDepth);

  // pi/2 with 62 fractional bits, and its split by the table size
  localparam logic [63:0] HalfPiQ62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] OneQ62    = 64'h4000000000000000;
  localparam logic [63:0] HpQuo     = HalfPiQ62 / 64'(LUT_SIZE);
  localparam logic [63:0] HpRem     = HalfPiQ62 % 64'(LUT_SIZE);
  localparam logic [63:0] TableSz   = 64'(LUT_SIZE);

  // Taylor series term divisors: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
  localparam logic [63:0] SinDiv [16] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
    64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
  };
  localparam logic [63:0] CosDiv [16] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
    64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992
  };

  typedef logic signed [AmpW-1:0] even_rom_t [EvenDepth];
  typedef logic signed [AmpW-1:0] odd_rom_t  [OddDepth];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // sin(pi/2 * x / LUT_SIZE) with 62 fractional bits, x in 0..LUT_SIZE
  function automatic logic [63:0] quarter_sine(logic [63:0] x);
    logic               use_cos;
    logic [63:0]        y;
    logic [63:0]        ang;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic [63:0]        prodm;
    logic signed [63:0] sum;
    use_cos = (x << 1) > TableSz;
    y       = use_cos ? TableSz - x : x;
    ang     = HpQuo * y + (HpRem * y) / TableSz;
    a2      = mul_q62(ang, ang);
    term    = use_cos ? OneQ62 : ang;
    sum     = signed'(term);
    for (int n = 0; n < 16; n++) begin
      prodm = mul_q62(term, a2);
      term  = use_cos ? prodm / CosDiv[n] : prodm / SinDiv[n];
      if ((n & 1) == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return unsigned'(sum);
  endfunction

  function automatic logic signed [AmpW-1:0] sine_entry(int k);
    logic [63:0] kk;
    logic [63:0] r4;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] mag;
    logic [63:0] v;
    kk  = (k == LUT_SIZE) ? 64'd0 : 64'(k);
    r4  = kk << 2;
    q   = r4 / TableSz;
    rem = r4 - q * TableSz;
    mag = q[0] ? quarter_sine(TableSz - rem) : quarter_sine(rem);
    v   = (mag + (64'd1 << (61 - AMP_FRAC_BITS))) >> (62 - AMP_FRAC_BITS);
    return (q >= 64'd2) ? AmpW'(-v) : AmpW'(v);
  endfunction

  function automatic even_rom_t build_even();
    even_rom_t r;
    for (int m = 0; m < EvenDepth; m++) begin
      r[m] = sine_entry(2 * m);
    end
    return r;
  endfunction

  function automatic odd_rom_t build_odd();
    odd_rom_t r;
    for (int m = 0; m < OddDepth; m++) begin
      r[m] = sine_entry(2 * m + 1);
    end
    return r;
  endfunction

  localparam even_rom_t EvenRom = build_even();
  localparam odd_rom_t  OddRom  = build_odd();

  logic [IdxW:0]          idx_inc;
  logic [EaddrW-1:0]      eaddr;
  logic [OaddrW-1:0]      oaddr;
  logic signed [AmpW-1:0] even_q;
  logic signed [AmpW-1:0] odd_q;
  logic                   odd_sel_q;

  // Entry idx and idx+1: the even one lives at (idx+1)/2, the odd one at idx/2.
  assign idx_inc = (IdxW + 1)'(idx_i) + (IdxW + 1)'(1);
  assign eaddr   = EaddrW'(idx_inc >> 1);
  assign oaddr   = OaddrW'(idx_i >> 1);

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      even_q    <= EvenRom[eaddr];
      odd_q     <= OddRom[oaddr];
      odd_sel_q <= idx_i[0];
    end
  end

  assign a_o = odd_sel_q ? odd_q : even_q;
  assign b_o = odd_sel_q ? even_q : odd_q;

endmodule

/* src/scli_lerp.sv */
// ----------------------------------------------------------------------------
// scli_lerp
// Three-stage linear interpolation between two table entries: difference,
// product with the fraction, then round half up and add back the base.
// ----------------------------------------------------------------------------
module scli_lerp import scli_pkg::*; #(
  parameter int PHASE_BITS    = 24,
  parameter int AMP_FRAC_BITS = 14,
  localparam int AmpW         = AMP_FRAC_BITS + 2
) (
  input  logic                   clk_i,
  input  scli_en_t               en_i,
  input  logic signed [AmpW-1:0] a_i,
  input  logic signed [AmpW-1:0] b_i,
  input  logic [PHASE_BITS-1:0]  frac_i,
  input  logic                   inv_i,
  input  logic signed [AmpW-1:0] force_i,
  output logic signed [15:0]     res_o
);

  localparam int ProdW = AmpW + PHASE_BITS + 2;

  logic signed [AmpW-1:0]  a3_d, a3_q;
  logic signed [AmpW:0]    d3_d, d3_q;
  logic [PHASE_BITS-1:0]   frac3_q;
  logic signed [AmpW-1:0]  a4_q;
  logic signed [ProdW-1:0] prod4_q;
  logic signed [ProdW-1:0] t5;
  logic signed [ProdW-1:0] sh5;
  logic signed [AmpW-1:0]  r5;
  logic signed [31:0]      r5_ext;
  logic signed [15:0]      res_d, res_q;

  // Invalid angle: replace the base by the forced value and zero the slope.
  always_comb begin
    a3_d = inv_i ? force_i : a_i;
    d3_d = inv_i ? '0 : (AmpW + 1)'(b_i) - (AmpW + 1)'(a_i);
  end

  // Round half up, floor shift; the result stays between the two entries.
  always_comb begin
    t5     = prod4_q + (ProdW'(1) <<< (PHASE_BITS - 1));
    sh5    = t5 >>> PHASE_BITS;
    r5     = a4_q + sh5[AmpW-1:0];
    r5_ext = 32'(r5);
    res_d  = r5_ext[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.diff) begin
      a3_q    <= a3_d;
      d3_q    <= d3_d;
      frac3_q <= frac_i;
    end
    if (en_i.mult) begin
      a4_q    <= a3_q;
      prod4_q <= ProdW'(d3_q) * ProdW'(signed'({1'b0, frac3_q}));
    end
    if (en_i.res) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* src/sin_cos_lut_interpolator.sv */
// ----------------------------------------------------------------------------
// sin_cos_lut_interpolator
// Phase to cosine/sine by table lookup with linear interpolation.
// ----------------------------------------------------------------------------
// Takes one angle word per clock, unless all stages are full and the output
// stalls, and returns its cosine and sine in signed Q2.14 format. The
// phase is a fraction of one turn, so it wraps naturally. Stage 1 scales the
// phase by LUT_SIZE into a table index and a fraction; stage 2 reads two
// neighboring entries from each of two copies of a constant sine table of
// LUT_SIZE+1 entries (one copy for the sine index, one for the cosine index
// a quarter table ahead), each split into an even and an odd bank with a
// registered read; stages 3 to 5 take the difference, multiply it by the
// fraction and round half up. A word flagged as an invalid angle returns
// cosine 1.0 and sine 0. Each stage carries its own valid bit and holds only
// while it is full and the stage behind it cannot load, so bubbles close up;
// a waiting result stops new words only once all five stages are full. The
// table is constant, so no start-up pass is needed after reset.
// ----------------------------------------------------------------------------
module sin_cos_lut_interpolator import scli_pkg::*; #(
  parameter int LUT_SIZE      = 1024,
  parameter int PHASE_BITS    = 24,
  parameter int AMP_FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  scli_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output scli_out_t out_data_o
);

  localparam int IdxW  = $clog2(LUT_SIZE);
  localparam int AmpW  = AMP_FRAC_BITS + 2;
  localparam int MulW  = PHASE_BITS + IdxW;
  localparam logic signed [AmpW-1:0] CosOne = AmpW'(1) << AMP_FRAC_BITS;
  localparam logic signed [AmpW-1:0] SinZero = '0;

  // --------------------------------------------------------------------------
  // Handshake: one valid bit per stage, a stage may load when it is empty or
  // the stage behind it loads in the same cycle.
  // --------------------------------------------------------------------------
  logic [5:1] vld_q;
  logic [5:1] vld_up;
  logic [6:1] rdy;
  scli_en_t   en;

  assign vld_up = {vld_q[4:1], in_valid_i};

  always_comb begin
    rdy[6] = out_ready_i;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 1; k <= 5; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_up[k];
        end
      end
    end
  end

  assign en.rom  = rdy[2];
  assign en.diff = rdy[3];
  assign en.mult = rdy[4];
  assign en.res  = rdy[5];

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld_q[5];

  // --------------------------------------------------------------------------
  // Stage 1: scale the phase by the table size. The integer part is the sine
  // index, the low PHASE_BITS bits are the interpolation fraction.
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_p;
  logic [MulW-1:0]       scaled;
  logic [IdxW-1:0]       i1_d, i1_q;
  logic [PHASE_BITS-1:0] frac1_q;
  logic                  inv1_q;

  assign phase_p = PHASE_BITS'(in_data_i.phase);
  assign scaled  = MulW'(phase_p) * MulW'(LUT_SIZE);
  assign i1_d    = scaled[MulW-1:PHASE_BITS];

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      i1_q    <= i1_d;
      frac1_q <= scaled[PHASE_BITS-1:0];
      inv1_q  <= in_data_i.angle_invalid;
    end
  end

  // Cosine index: a quarter table ahead, wrapped once.
  logic [IdxW:0]   j_sum;
  logic [IdxW-1:0] j1;

  always_comb begin
    j_sum = (IdxW + 1)'(i1_q) + (IdxW + 1)'(LUT_SIZE / 4);
    if (j_sum >= (IdxW + 1)'(LUT_SIZE)) begin
      j1 = IdxW'(j_sum - (IdxW + 1)'(LUT_SIZE));
    end else begin
      j1 = IdxW'(j_sum);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: table reads; carry the fraction and the invalid flag alongside.
  // --------------------------------------------------------------------------
  logic [PHASE_BITS-1:0]  frac2_q;
  logic                   inv2_q;
  logic signed [AmpW-1:0] sin_a, sin_b, cos_a, cos_b;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      frac2_q <= frac1_q;
      inv2_q  <= inv1_q;
    end
  end

  scli_rom #(
    .LUT_SIZE      (LUT_SIZE),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_sin_rom (
    .clk_i (clk_i),
    .ld_i  (en.rom),
    .idx_i (i1_q),
    .a_o   (sin_a),
    .b_o   (sin_b)
  );

  scli_rom #(
    .LUT_SIZE      (LUT_SIZE),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_cos_rom (
    .clk_i (clk_i),
    .ld_i  (en.rom),
    .idx_i (j1),
    .a_o   (cos_a),
    .b_o   (cos_b)
  );

  // --------------------------------------------------------------------------
  // Stages 3 to 5: interpolate each channel; an invalid angle forces the
  // cosine to one and the sine to zero.
  // --------------------------------------------------------------------------
  logic signed [15:0] cos_res, sin_res;

  scli_lerp #(
    .PHASE_BITS    (PHASE_BITS),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_cos_lerp (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (cos_a),
    .b_i     (cos_b),
    .frac_i  (frac2_q),
    .inv_i   (inv2_q),
    .force_i (CosOne),
    .res_o   (cos_res)
  );

  scli_lerp #(
    .PHASE_BITS    (PHASE_BITS),
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
  ) u_sin_lerp (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (sin_a),
    .b_i     (sin_b),
    .frac_i  (frac2_q),
    .inv_i   (inv2_q),
    .force_i (SinZero),
    .res_o   (sin_res)
  );

  assign out_data_o = '{cosine: cos_res, sine: sin_res};

endmodule
